// ===== src/crp_pkg.sv =====
package crp_pkg;

    // column letters allowed in one corner
    localparam int unsigned MAX_LETTERS = 3;

    localparam int unsigned COL_W = 15;
    localparam int unsigned ROW_W = 20;
    localparam int unsigned ROW_ACC_W = 21;
    localparam int unsigned CFG_DATA_W = 21;

    localparam logic [ROW_ACC_W-1:0] ROW_CAP = 21'd1048576;
    localparam logic [COL_W-1:0] COL_CAP = 15'd18278;
    localparam logic [COL_W-1:0] COL_LIMIT_RESET = 15'd16384;
    localparam logic [ROW_ACC_W-1:0] ROW_SAT = 21'd2097151;
    localparam logic [4:0] COL_RADIX = 5'd26;
    localparam logic [3:0] ROW_RADIX = 4'd10;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // configuration register indexes
    localparam logic CFG_ROW_LIMIT = 1'b0;
    localparam logic CFG_COLUMN_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        PH_START,
        PH_AFTER_LEAD,
        PH_LETTERS,
        PH_AFTER_ROWD,
        PH_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_CHAR,
        ERR_COUNT,
        ERR_RANGE
    } err_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_item_t;

    typedef struct packed {
        logic [COL_W-1:0] first_column;
        logic [ROW_W-1:0] first_row;
        logic             first_absolute;
        logic [COL_W-1:0] second_column;
        logic [ROW_W-1:0] second_row;
        logic             second_absolute;
        logic             is_range;
        logic [1:0]       error_code;
    } result_item_t;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             absolute;
    } corner_t;

    typedef struct packed {
        phase_t               phase;
        logic [COL_W-1:0]     col_acc;
        logic [1:0]           letter_count;
        logic [ROW_ACC_W-1:0] row_acc;
        logic                 digit_seen;
        logic                 dollar_seen;
        logic                 in_second;
        corner_t              saved_first;
        err_t                 err;
    } parse_state_t;

    typedef struct packed {
        logic    order_bad;
        logic    range_bad;
        corner_t corner;
    } corner_check_t;

    localparam parse_state_t PARSE_CLEAR = '0;

endpackage

// ===== src/crp_corner_check.sv =====
module crp_corner_check (
    input  crp_pkg::parse_state_t         state,
    input  logic [crp_pkg::ROW_ACC_W-1:0] row_limit,
    input  logic [crp_pkg::COL_W-1:0]     column_limit,
    output crp_pkg::corner_check_t        check
);

    logic [crp_pkg::ROW_ACC_W-1:0] row_zero_based;
    logic [crp_pkg::COL_W-1:0]     col_zero_based;

    assign row_zero_based = state.row_acc - 21'd1;
    assign col_zero_based = state.col_acc - 15'd1;

    always_comb
    begin
        check.order_bad = (state.phase != crp_pkg::PH_DIGITS) || !state.digit_seen
                          || (state.letter_count == 2'd0);
        check.range_bad = (state.row_acc == '0) || (state.row_acc > row_limit)
                          || (state.col_acc == '0) || (state.col_acc > column_limit);
        check.corner.column   = col_zero_based;
        check.corner.row      = row_zero_based[crp_pkg::ROW_W-1:0];
        check.corner.absolute = state.dollar_seen;
    end

endmodule

// ===== src/crp_char_step.sv =====
module crp_char_step (
    input  crp_pkg::parse_state_t         state,
    input  crp_pkg::char_item_t           item,
    input  logic [crp_pkg::ROW_ACC_W-1:0] row_limit,
    input  logic [crp_pkg::COL_W-1:0]     column_limit,
    output crp_pkg::parse_state_t         state_next,
    output crp_pkg::result_item_t         result
);

    crp_pkg::parse_state_t  taken;
    crp_pkg::corner_check_t check_old;
    crp_pkg::corner_check_t check_new;
    crp_pkg::err_t          final_err;
    logic                   is_letter;
    logic                   is_digit;
    logic [7:0]             upper_code;
    logic [7:0]             letter_value;
    logic [7:0]             digit_value;
    logic [19:0]            col_product;
    logic [24:0]            row_product;

    // old state serves the ':' corner end, updated state the final corner end
    crp_corner_check u_check_old (
        .state        (state),
        .row_limit    (row_limit),
        .column_limit (column_limit),
        .check        (check_old)
    );

    crp_corner_check u_check_new (
        .state        (taken),
        .row_limit    (row_limit),
        .column_limit (column_limit),
        .check        (check_new)
    );

    assign is_letter = ((item.char_code >= crp_pkg::CHAR_UPPER_A)
                        && (item.char_code <= crp_pkg::CHAR_UPPER_Z))
                       || ((item.char_code >= crp_pkg::CHAR_LOWER_A)
                        && (item.char_code <= crp_pkg::CHAR_LOWER_Z));
    assign is_digit = (item.char_code >= crp_pkg::CHAR_ZERO)
                      && (item.char_code <= crp_pkg::CHAR_NINE);

    assign upper_code = (item.char_code >= crp_pkg::CHAR_LOWER_A)
                        ? item.char_code - crp_pkg::CASE_OFFSET : item.char_code;
    assign letter_value = upper_code - crp_pkg::CHAR_UPPER_A + 8'd1;
    assign digit_value = item.char_code - crp_pkg::CHAR_ZERO;

    assign col_product = {5'd0, state.col_acc} * {15'd0, crp_pkg::COL_RADIX}
                         + {15'd0, letter_value[4:0]};
    assign row_product = {4'd0, state.row_acc} * {21'd0, crp_pkg::ROW_RADIX}
                         + {21'd0, digit_value[3:0]};

    // character update
    always_comb
    begin
        taken = state;
        if (state.err == crp_pkg::ERR_NONE)
        begin
            if (is_letter)
            begin
                if (state.phase inside {crp_pkg::PH_START, crp_pkg::PH_AFTER_LEAD,
                                        crp_pkg::PH_LETTERS})
                begin
                    if (state.letter_count >= 2'(crp_pkg::MAX_LETTERS))
                    begin
                        taken.err = crp_pkg::ERR_COUNT;
                    end
                    else
                    begin
                        taken.col_acc      = col_product[crp_pkg::COL_W-1:0];
                        taken.letter_count = state.letter_count + 2'd1;
                        taken.phase        = crp_pkg::PH_LETTERS;
                    end
                end
                else
                begin
                    taken.err = crp_pkg::ERR_CHAR;
                end
            end
            else if (is_digit)
            begin
                if (state.phase inside {crp_pkg::PH_LETTERS, crp_pkg::PH_AFTER_ROWD,
                                        crp_pkg::PH_DIGITS})
                begin
                    // saturate once the decimal value passes ROW_SAT, the largest accumulator value
                    if (row_product > {4'd0, crp_pkg::ROW_SAT})
                        taken.row_acc = crp_pkg::ROW_SAT;
                    else
                        taken.row_acc = row_product[crp_pkg::ROW_ACC_W-1:0];
                    taken.digit_seen = 1'b1;
                    taken.phase      = crp_pkg::PH_DIGITS;
                end
                else
                begin
                    taken.err = crp_pkg::ERR_CHAR;
                end
            end
            else if (item.char_code == crp_pkg::CHAR_DOLLAR)
            begin
                case (state.phase)
                    crp_pkg::PH_START:
                    begin
                        taken.dollar_seen = 1'b1;
                        taken.phase       = crp_pkg::PH_AFTER_LEAD;
                    end
                    crp_pkg::PH_LETTERS:
                    begin
                        taken.dollar_seen = 1'b1;
                        taken.phase       = crp_pkg::PH_AFTER_ROWD;
                    end
                    default:
                    begin
                        taken.err = crp_pkg::ERR_CHAR;
                    end
                endcase
            end
            else if (item.char_code == crp_pkg::CHAR_COLON)
            begin
                if ((state.phase == crp_pkg::PH_DIGITS) && !state.in_second)
                begin
                    if (check_old.order_bad)
                    begin
                        taken.err = crp_pkg::ERR_CHAR;
                    end
                    else if (check_old.range_bad)
                    begin
                        taken.err = crp_pkg::ERR_RANGE;
                    end
                    else
                    begin
                        taken             = crp_pkg::PARSE_CLEAR;
                        taken.saved_first = check_old.corner;
                        taken.in_second   = 1'b1;
                    end
                end
                else
                begin
                    taken.err = crp_pkg::ERR_CHAR;
                end
            end
            else
            begin
                taken.err = crp_pkg::ERR_CHAR;
            end
        end
    end

    // next state: back to clear after the final character
    always_comb
    begin
        if (item.last_char)
            state_next = crp_pkg::PARSE_CLEAR;
        else
            state_next = taken;
    end

    // result for the final character
    always_comb
    begin
        final_err = taken.err;
        if (taken.err == crp_pkg::ERR_NONE)
        begin
            if (check_new.order_bad)
                final_err = crp_pkg::ERR_CHAR;
            else if (check_new.range_bad)
                final_err = crp_pkg::ERR_RANGE;
        end

        result = '0;
        result.error_code = final_err;
        if (final_err == crp_pkg::ERR_NONE)
        begin
            if (taken.in_second)
            begin
                result.first_column   = taken.saved_first.column;
                result.first_row      = taken.saved_first.row;
                result.first_absolute = taken.saved_first.absolute;
            end
            else
            begin
                result.first_column   = check_new.corner.column;
                result.first_row      = check_new.corner.row;
                result.first_absolute = check_new.corner.absolute;
            end
            result.second_column   = check_new.corner.column;
            result.second_row      = check_new.corner.row;
            result.second_absolute = check_new.corner.absolute;
            result.is_range        = taken.in_second;
        end
    end

endmodule

// ===== src/cell_reference_parser.sv =====
// channel   direction  signals                                   transaction
// char      in         char_valid, char_ready, char_item          one character of the text
// result    out        result_valid, result_ready, result_item    one parsed reference
// cfg       in         cfg_valid, cfg_ready, cfg_index, cfg_data  one limit register write
//
// one character per cycle sustained, except while a waiting result holds back a final character
// the character register feeds one pass of parse logic into the parse state and result register
// rst_n clears the parse state, the valid flags and restores both limits
// a waiting result only holds back a final character; other characters keep flowing
// limits are clamped to their caps when written; cfg_ready is always high
module cell_reference_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           char_valid,
    output logic                           char_ready,
    input  crp_pkg::char_item_t            char_item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output crp_pkg::result_item_t          result_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [crp_pkg::CFG_DATA_W-1:0] cfg_data
);

    // input stage
    logic                  char_valid_reg;
    logic                  char_valid_next;
    crp_pkg::char_item_t   char_item_reg;

    // parse state carried from character to character
    crp_pkg::parse_state_t state_reg;
    crp_pkg::parse_state_t state_next;

    // result stage
    logic                  result_valid_reg;
    logic                  result_valid_next;
    crp_pkg::result_item_t result_item_reg;
    crp_pkg::result_item_t step_result;

    // limit registers, stored already clamped
    logic [crp_pkg::ROW_ACC_W-1:0] row_limit_reg;
    logic [crp_pkg::COL_W-1:0]     column_limit_reg;
    logic [crp_pkg::ROW_ACC_W-1:0] row_limit_next;
    logic [crp_pkg::COL_W-1:0]     column_limit_next;

    logic advance;

    crp_char_step u_step (
        .state        (state_reg),
        .item         (char_item_reg),
        .row_limit    (row_limit_reg),
        .column_limit (column_limit_reg),
        .state_next   (state_next),
        .result       (step_result)
    );

    // the held character moves on unless it would overwrite an untaken result
    assign advance = char_valid_reg
                     && (!char_item_reg.last_char || !result_valid_reg || result_ready);
    assign char_ready = !char_valid_reg || advance;

    assign char_valid_next = char_ready ? char_valid : char_valid_reg;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (advance && char_item_reg.last_char)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    assign cfg_ready = 1'b1;

    // clamp limits on write
    always_comb
    begin
        row_limit_next    = row_limit_reg;
        column_limit_next = column_limit_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                crp_pkg::CFG_ROW_LIMIT:
                begin
                    if (cfg_data > crp_pkg::ROW_CAP)
                        row_limit_next = crp_pkg::ROW_CAP;
                    else
                        row_limit_next = cfg_data;
                end
                crp_pkg::CFG_COLUMN_LIMIT:
                begin
                    if (cfg_data[crp_pkg::COL_W-1:0] > crp_pkg::COL_CAP)
                        column_limit_next = crp_pkg::COL_CAP;
                    else
                        column_limit_next = cfg_data[crp_pkg::COL_W-1:0];
                end
                default:
                begin
                    row_limit_next = row_limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= crp_pkg::PARSE_CLEAR;
            row_limit_reg    <= crp_pkg::ROW_CAP;
            column_limit_reg <= crp_pkg::COL_LIMIT_RESET;
        end
        else
        begin
            char_valid_reg   <= char_valid_next;
            result_valid_reg <= result_valid_next;
            row_limit_reg    <= row_limit_next;
            column_limit_reg <= column_limit_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
            char_item_reg <= char_item;
        if (advance && char_item_reg.last_char)
            result_item_reg <= step_result;
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

endmodule

// ===== dv/cell_ref_checker.sv =====
module cell_ref_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           char_valid,
    input  logic                           char_ready,
    input  crp_pkg::char_item_t            char_item,
    input  logic                           result_valid,
    input  logic                           result_ready,
    input  crp_pkg::result_item_t          result_item,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [crp_pkg::CFG_DATA_W-1:0] cfg_data,
    output int unsigned                    waiting,
    output int unsigned                    mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import crp_pkg::*;

    // parser state as the design should hold it
    phase_t               ph;
    logic [COL_W-1:0]     col_acc;
    logic [1:0]           letters;
    logic [ROW_ACC_W-1:0] row_acc;
    logic                 digit_seen;
    logic                 dollar_seen;
    logic                 in_second;
    corner_t              first_corner;
    err_t                 err;

    logic [ROW_ACC_W-1:0] row_lim;
    logic [COL_W-1:0]     col_lim;

    result_item_t refs_due[$];
    int unsigned  result_no;
    int unsigned  miss_count = 0;

    assign mismatches = miss_count;

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        miss_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("reference %0d %s: got %0d, expected %0d",
                                      result_no, name, got, want));
    endtask

    task automatic latch_error(input err_t code);
        if (err == ERR_NONE)
            err = code;
    endtask

    task automatic restart_corner();
        ph = PH_START;
        col_acc = '0;
        letters = '0;
        row_acc = '0;
        digit_seen = 1'b0;
        dollar_seen = 1'b0;
    endtask

    task automatic restart_parse();
        restart_corner();
        in_second = 1'b0;
        first_corner = '0;
        err = ERR_NONE;
    endtask

    // checks the corner that just ended and returns it zero-based
    task automatic close_corner(output corner_t c);
        logic [ROW_ACC_W-1:0] rows_ok;
        logic [COL_W-1:0]     cols_ok;
        rows_ok = (row_lim < ROW_CAP) ? row_lim : ROW_CAP;
        cols_ok = (col_lim < COL_CAP) ? col_lim : COL_CAP;
        c = '0;
        if (ph != PH_DIGITS || !digit_seen || letters == 0)
            latch_error(ERR_CHAR);
        else if (row_acc == 0 || row_acc > rows_ok || col_acc == 0 || col_acc > cols_ok)
            latch_error(ERR_RANGE);
        else
        begin
            c.column = col_acc - 1'b1;
            c.row = ROW_W'(row_acc - 1'b1);
            c.absolute = dollar_seen;
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic        is_letter;
        logic        is_digit;
        int unsigned up;
        int unsigned d;
        corner_t     done;
        is_letter = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
                    (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
        is_digit = c >= CHAR_ZERO && c <= CHAR_NINE;
        if (err == ERR_NONE)
        begin
            if (is_letter)
            begin
                if (ph == PH_START || ph == PH_AFTER_LEAD || ph == PH_LETTERS)
                begin
                    if (letters >= MAX_LETTERS)
                        latch_error(ERR_COUNT);
                    else
                    begin
                        up = (c >= CHAR_LOWER_A) ? c - CASE_OFFSET : c;
                        col_acc = COL_W'(col_acc * COL_RADIX + (up - CHAR_UPPER_A + 1));
                        letters++;
                        ph = PH_LETTERS;
                    end
                end
                else
                    latch_error(ERR_CHAR);
            end
            else if (is_digit)
            begin
                if (ph == PH_LETTERS || ph == PH_AFTER_ROWD || ph == PH_DIGITS)
                begin
                    d = c - CHAR_ZERO;
                    if (row_acc > (ROW_SAT - d) / ROW_RADIX)
                        row_acc = ROW_SAT;
                    else
                        row_acc = ROW_ACC_W'(row_acc * ROW_RADIX + d);
                    digit_seen = 1'b1;
                    ph = PH_DIGITS;
                end
                else
                    latch_error(ERR_CHAR);
            end
            else if (c == CHAR_DOLLAR)
            begin
                if (ph == PH_START)
                begin
                    dollar_seen = 1'b1;
                    ph = PH_AFTER_LEAD;
                end
                else if (ph == PH_LETTERS)
                begin
                    dollar_seen = 1'b1;
                    ph = PH_AFTER_ROWD;
                end
                else
                    latch_error(ERR_CHAR);
            end
            else if (c == CHAR_COLON)
            begin
                if (ph == PH_DIGITS && !in_second)
                begin
                    close_corner(done);
                    first_corner = done;
                    if (err == ERR_NONE)
                    begin
                        restart_corner();
                        in_second = 1'b1;
                    end
                end
                else
                    latch_error(ERR_CHAR);
            end
            else
                latch_error(ERR_CHAR);
        end
    endtask

    // one accepted character; the final one of a reference queues its result
    task automatic predict_ref(input char_item_t item);
        corner_t      lead;
        corner_t      tail;
        result_item_t r;
        parse_char(item.char_code);
        if (item.last_char)
        begin
            r = '0;
            lead = '0;
            tail = '0;
            if (err == ERR_NONE)
            begin
                close_corner(tail);
                lead = in_second ? first_corner : tail;
            end
            if (err != ERR_NONE)
                r.error_code = err;
            else
            begin
                r.first_column = lead.column;
                r.first_row = lead.row;
                r.first_absolute = lead.absolute;
                r.second_column = tail.column;
                r.second_row = tail.row;
                r.second_absolute = tail.absolute;
                r.is_range = in_second;
            end
            refs_due.push_back(r);
            restart_parse();
        end
    endtask

    task automatic check_result(input result_item_t got);
        result_item_t want;
        result_no++;
        if (refs_due.size() == 0)
            report_mismatch($sformatf("reference %0d arrived with none expected", result_no));
        else
        begin
            want = refs_due.pop_front();
            compare_field("first_column", got.first_column, want.first_column);
            compare_field("first_row", got.first_row, want.first_row);
            compare_field("first_absolute", got.first_absolute, want.first_absolute);
            compare_field("second_column", got.second_column, want.second_column);
            compare_field("second_row", got.second_row, want.second_row);
            compare_field("second_absolute", got.second_absolute, want.second_absolute);
            compare_field("is_range", got.is_range, want.is_range);
            compare_field("error_code", got.error_code, want.error_code);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_parse();
            row_lim = ROW_CAP;
            col_lim = COL_LIMIT_RESET;
            refs_due.delete();
            result_no = 0;
            waiting <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
                check_result(result_item);
            if (char_valid && char_ready)
                predict_ref(char_item);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ROW_LIMIT)
                    row_lim = cfg_data[ROW_ACC_W-1:0];
                else
                    col_lim = cfg_data[COL_W-1:0];
            end
            waiting <= refs_due.size();
        end
    end

endmodule

// ===== dv/cell_reference_parser_tb.sv =====
module cell_reference_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crp_pkg::*;

    // characters of random text per limit setting, and number of settings
    localparam int unsigned PHASE_CHARS = 75;
    localparam int unsigned N_PHASES = 8;

    typedef logic [7:0] text_t[$];

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  char_valid;
    logic                  char_ready;
    char_item_t            char_item;
    logic                  result_valid;
    logic                  result_ready;
    result_item_t          result_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned refs_waiting;
    int unsigned mismatches;

    // idling controls: odds of a gap before a character or a stall on results,
    // zero meaning none; calm switches both off for the closing stretch
    bit          calm = 1'b0;
    int unsigned gap_odds = 4;
    int unsigned stall_odds = 4;
    int unsigned chars_in_phase;

    // limits as the parser applies them, used to aim rows and columns at the edges
    int unsigned eff_rows = ROW_CAP;
    int unsigned eff_cols = COL_LIMIT_RESET;

    always #2 clk = ~clk;

    cell_reference_parser u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_item    (char_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // watches all three channels, predicts every parsed reference and compares
    cell_ref_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_item    (char_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .waiting      (refs_waiting),
        .mismatches   (mismatches)
    );

    function automatic int unsigned pick_odds();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 2;
            2: return 4;
            default: return 12;
        endcase
    endfunction

    // any byte, weighted toward the characters the parser cares about
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 5))
            0: return CHAR_DOLLAR;
            1: return CHAR_COLON;
            2: return CHAR_UPPER_A + 8'($urandom_range(0, 25));
            3: return CHAR_LOWER_A + 8'($urandom_range(0, 25));
            4: return CHAR_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one corner: optional dollar, letters in bijective base 26, optional dollar, digits
    function automatic text_t make_corner();
        text_t t;
        text_t lt;
        string digits;
        int    col;
        int    row;
        int    n;
        int    i;
        if ($urandom_range(0, 1))
            t.push_back(CHAR_DOLLAR);
        case ($urandom_range(0, 5))
            0: col = $urandom_range(1, 26);
            1: col = $urandom_range(1, 18278);
            2: col = int'(eff_cols) + $urandom_range(0, 4) - 2;
            3:
            begin
                case ($urandom_range(0, 5))
                    0: col = 1;
                    1: col = 26;
                    2: col = 27;
                    3: col = 702;
                    4: col = 703;
                    default: col = 18278;
                endcase
            end
            default: col = $urandom_range(1, 702);
        endcase
        if (col < 1)
            col = 1;
        if (col > 18278)
            col = 18278;
        n = col;
        while (n > 0)
        begin
            n = n - 1;
            lt.push_front(CHAR_UPPER_A + 8'(n % 26));
            n = n / 26;
        end
        // now and then an extra letter, which trips the letter count when three are already there
        if ($urandom_range(0, 11) == 0)
            lt.push_back(CHAR_UPPER_A + 8'($urandom_range(0, 25)));
        foreach (lt[k])
            t.push_back($urandom_range(0, 1) ? lt[k] + CASE_OFFSET : lt[k]);
        if ($urandom_range(0, 2) == 0)
            t.push_back(CHAR_DOLLAR);
        case ($urandom_range(0, 4))
            0: row = $urandom_range(1, 30);
            1: row = int'(eff_rows) + $urandom_range(0, 4) - 2;
            2: row = $urandom_range(0, 1048580);
            default: row = $urandom_range(1, 9999);
        endcase
        if (row < 0)
            row = 0;
        digits = $sformatf("%0d", row);
        case ($urandom_range(0, 7))
            // a long run of random digits, often past the row saturation point
            0:
            begin
                digits = "";
                n = $urandom_range(7, 11);
                for (i = 0; i < n; i++)
                    digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
            end
            1: digits = {"00", digits};
            default: ;
        endcase
        for (i = 0; i < digits.len(); i++)
            t.push_back(digits[i]);
        return t;
    endfunction

    // mostly well-formed cells and ranges; the rest damaged or plain junk
    function automatic text_t make_ref();
        text_t t;
        text_t tail;
        int    pos;
        int    i;
        t = make_corner();
        if ($urandom_range(0, 2) == 0)
        begin
            t.push_back(CHAR_COLON);
            tail = make_corner();
            foreach (tail[k])
                t.push_back(tail[k]);
        end
        if ($urandom_range(0, 4) == 0)
        begin
            pos = $urandom_range(0, t.size() - 1);
            case ($urandom_range(0, 4))
                0: t[pos] = pick_char();
                1: t.insert(pos, pick_char());
                2:
                begin
                    if (t.size() > 1)
                        t.delete(pos);
                end
                3:
                begin
                    // cut short, often leaving no row digits
                    while (t.size() > pos + 1)
                        void'(t.pop_back());
                end
                default:
                begin
                    t.delete();
                    for (i = 0; i < $urandom_range(1, 6); i++)
                        t.push_back(pick_char());
                end
            endcase
        end
        return t;
    endfunction

    // one character transaction, with an occasional gap ahead of it
    task automatic send_char(input logic [7:0] code, input logic last);
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_item <= {code, last};
        @(posedge clk);
        while (!char_ready)
            @(posedge clk);
        chars_in_phase++;
    endtask

    task automatic send_ref(input text_t t);
        for (int i = 0; i < t.size(); i++)
            send_char(t[i], i == t.size() - 1);
    endtask

    task automatic send_text(input string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
        send_ref(t);
    endtask

    // stop sending, let every expected reference come back, then let the pipe empty
    task automatic wait_idle();
        char_valid <= 1'b0;
        @(posedge clk);
        while (refs_waiting != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic index, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // both limit registers back to back, only while the parser is idle
    task automatic set_limits(input logic [CFG_DATA_W-1:0] rows,
                              input logic [CFG_DATA_W-1:0] cols);
        write_limit(CFG_ROW_LIMIT, rows);
        write_limit(CFG_COLUMN_LIMIT, cols);
        cfg_valid <= 1'b0;
        eff_rows = (rows > ROW_CAP) ? ROW_CAP : rows;
        eff_cols = (cols[COL_W-1:0] > COL_CAP) ? COL_CAP : cols[COL_W-1:0];
    endtask

    // result side: ready drops in bursts unless stalls are off
    initial
    begin
        result_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            result_ready <= 1'b1;
        end
    end

    initial
    begin
        #(2_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int unsigned p;
        rst_n <= 1'b0;
        char_valid <= 1'b0;
        char_item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_ROW_LIMIT;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed references under the reset limits
        send_text("A1");
        send_text("$C$7");
        send_text("b12");
        send_text("A1:D20");
        send_text("$a$1:$XfD$1048576");
        send_text("XFD1048576");
        // column one past the limit, row one past the limit, row zero
        send_text("XFE1");
        send_text("A1048577");
        send_text("A0");
        send_text("ZZZ9");
        // four letters
        send_text("ABCD1");
        // characters out of order
        send_text("1A");
        send_text("A");
        send_text("A1:B2:C3");
        send_text("A$$1");
        send_text("$$A1");
        send_text("A1$");
        send_text("A1:");
        send_text(":A1");
        // row saturation and leading zeros
        send_text("A99999999999");
        send_text("a007");
        // bad character then more characters that must be ignored
        send_text("A#1");
        send_ref('{CHAR_UPPER_A, 8'hC1, CHAR_ZERO + 8'd1});
        send_ref('{8'h80});
        send_ref('{8'hFF});
        wait_idle();

        for (p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0: set_limits(21'd1, 21'd1);
                1: set_limits(ROW_CAP, 21'(COL_CAP));
                // above the caps, upper data bits set on the column write
                2: set_limits(21'h1FFFFF, {6'($urandom_range(0, 63)), 15'h7FFF});
                // zero limits reject every corner
                3: set_limits(21'd0, 21'd0);
                4: set_limits(21'($urandom_range(1, 40)), 21'($urandom_range(1, 60)));
                5: set_limits(21'($urandom_range(1, 1048576)), 21'($urandom_range(1, 18278)));
                6: set_limits(21'd1000, 21'd702);
                default: set_limits(ROW_CAP, 21'(COL_LIMIT_RESET));
            endcase
            calm = (p == N_PHASES - 1);
            gap_odds = pick_odds();
            stall_odds = pick_odds();
            chars_in_phase = 0;
            while (chars_in_phase < PHASE_CHARS)
            begin
                if ($urandom_range(0, 14) == 0)
                begin
                    gap_odds = pick_odds();
                    stall_odds = pick_odds();
                end
                send_ref(make_ref());
            end
            wait_idle();
        end

        if (mismatches == 0 && refs_waiting == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
